FILE: design/lsf_pkg.sv
package lsf_pkg;

    localparam int MAX_POINTS     = 256;
    localparam int MIN_POINTS_RST = 5;
    localparam int MIN_FIT_POINTS = 2;

    localparam int X_W     = 16;
    localparam int CNT_W   = 9;
    localparam int SX_W    = X_W + $clog2(MAX_POINTS);
    localparam int SXX_W   = 2 * X_W + $clog2(MAX_POINTS);
    localparam int MUL_A_W = SX_W;
    localparam int MUL_B_W = (SXX_W + 1) / 2;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = SX_W + SXX_W;
    localparam int DEN_W   = SXX_W + CNT_W;
    localparam int Q_W     = 32;
    localparam int ST_W    = 2;

    localparam int SLOPE_SHIFT = 20;
    localparam int ICPT_SHIFT  = 12;
    localparam int DIV_N_W     = ACC_W + ICPT_SHIFT;
    localparam int DIV_CNT_W   = $clog2(DIV_N_W + 1);

    typedef enum logic [ST_W-1:0] {
        FIT_OK   = 2'd0,
        FIT_FEW  = 2'd1,
        FIT_FLAT = 2'd2,
        FIT_OVF  = 2'd3
    } t_fit_status;

    // product selection for the shared multiplier, in program order
    typedef enum logic [2:0] {
        MOP_N_XX = 3'd0,
        MOP_X_X  = 3'd1,
        MOP_N_XY = 3'd2,
        MOP_X_Y  = 3'd3,
        MOP_Y_XX = 3'd4,
        MOP_X_XY = 3'd5
    } t_mop;

    typedef struct packed {
        logic        accum;
        logic        clear;
        logic        mul_en;
        logic        mul_hi;
        t_mop        mop;
        logic        store_ta;
        logic        store_den;
        logic        store_num;
        logic        shift_icpt;
        logic        div_step;
        logic        save_slope;
        logic        save_icpt;
        logic        publish;
        t_fit_status status;
    } t_lsf_cmd;

    typedef struct packed {
        logic overflowed;
        logic too_few;
        logic den_bad;
    } t_lsf_sts;

endpackage

FILE: design/lsf_point_if.sv
interface lsf_point_if;
    logic                      valid;
    logic                      ready;
    logic [lsf_pkg::X_W-1:0]   payload_mass;
    logic [lsf_pkg::X_W-1:0]   energy_per_km;
    logic                      last;

    modport source (output valid, output payload_mass, output energy_per_km, output last,
                    input ready);
    modport sink   (input valid, input payload_mass, input energy_per_km, input last,
                    output ready);
endinterface

FILE: design/lsf_result_if.sv
interface lsf_result_if;
    logic                      valid;
    logic                      ready;
    logic signed [lsf_pkg::Q_W-1:0] slope;
    logic signed [lsf_pkg::Q_W-1:0] intercept;
    logic [lsf_pkg::ST_W-1:0]  fit_status;
    logic [lsf_pkg::CNT_W-1:0] point_count;

    modport source (output valid, output slope, output intercept, output fit_status,
                    output point_count, input ready);
    modport sink   (input valid, input slope, input intercept, input fit_status,
                    input point_count, output ready);
endinterface

FILE: design/lsf_ctrl.sv
module lsf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    input  logic              i_out_ready,
    input  lsf_pkg::t_lsf_sts i_sts,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output lsf_pkg::t_lsf_cmd o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_DEN   = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        PH_LO    = 2'd0,
        PH_HI    = 2'd1,
        PH_ADD   = 2'd2,
        PH_STORE = 2'd3
    } t_phase;

    t_state                        r_state, n_state;
    t_phase                        r_phase, n_phase;
    logic [2:0]                    r_idx, n_idx;
    logic [lsf_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    lsf_pkg::t_fit_status          r_status, n_status;
    logic                          r_out_vld, n_out_vld;
    lsf_pkg::t_lsf_cmd             cmd;

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_status  = r_status;
        n_out_vld = r_out_vld;
        cmd        = '0;
        cmd.mop    = lsf_pkg::MOP_N_XX;
        cmd.status = r_status;

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.accum = 1'b1;
                    if (i_in_last) begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (i_sts.overflowed) begin
                    n_status = lsf_pkg::FIT_OVF;
                    n_state  = ST_DONE;
                end else if (i_sts.too_few) begin
                    n_status = lsf_pkg::FIT_FEW;
                    n_state  = ST_DONE;
                end else begin
                    n_status = lsf_pkg::FIT_OK;
                    n_idx    = lsf_pkg::MOP_N_XX;
                    n_phase  = PH_LO;
                    n_state  = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mop = lsf_pkg::t_mop'(r_idx);
                case (r_phase)
                    PH_LO: begin
                        cmd.mul_en = 1'b1;
                        n_phase    = PH_HI;
                    end
                    PH_HI: begin
                        cmd.mul_en = 1'b1;
                        cmd.mul_hi = 1'b1;
                        n_phase    = PH_ADD;
                    end
                    PH_ADD: begin
                        n_phase = PH_STORE;
                    end
                    PH_STORE: begin
                        n_phase = PH_LO;
                        n_idx   = r_idx + 3'd1;
                        case (lsf_pkg::t_mop'(r_idx))
                            lsf_pkg::MOP_N_XX, lsf_pkg::MOP_N_XY, lsf_pkg::MOP_Y_XX: begin
                                cmd.store_ta = 1'b1;
                            end
                            lsf_pkg::MOP_X_X: begin
                                cmd.store_den = 1'b1;
                                n_state       = ST_DEN;
                            end
                            lsf_pkg::MOP_X_Y: begin
                                cmd.store_num = 1'b1;
                                n_cnt         = '0;
                                n_state       = ST_DIV;
                            end
                            lsf_pkg::MOP_X_XY: begin
                                cmd.store_num  = 1'b1;
                                cmd.shift_icpt = 1'b1;
                                n_cnt          = '0;
                                n_state        = ST_DIV;
                            end
                            default: begin
                                n_state = ST_IDLE;
                            end
                        endcase
                    end
                    default: begin
                        n_phase = PH_LO;
                    end
                endcase
            end
            ST_DEN: begin
                if (i_sts.den_bad) begin
                    n_status = lsf_pkg::FIT_FLAT;
                    n_state  = ST_DONE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_DIV: begin
                if (r_cnt != lsf_pkg::DIV_CNT_W'(lsf_pkg::DIV_N_W)) begin
                    cmd.div_step = 1'b1;
                    n_cnt        = r_cnt + 1'b1;
                end else if (r_idx == lsf_pkg::MOP_Y_XX) begin
                    // slope done, go on with the intercept products
                    cmd.save_slope = 1'b1;
                    n_state        = ST_MUL;
                end else begin
                    cmd.save_icpt = 1'b1;
                    n_state       = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_vld || i_out_ready) begin
                    cmd.publish = 1'b1;
                    cmd.clear   = 1'b1;
                    n_out_vld   = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= PH_LO;
            r_idx     <= '0;
            r_cnt     <= '0;
            r_status  <= lsf_pkg::FIT_OK;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_cnt     <= n_cnt;
            r_status  <= n_status;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_cmd       = cmd;

endmodule

FILE: design/lsf_dp.sv
module lsf_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lsf_pkg::t_lsf_cmd                i_cmd,
    input  logic                             i_cfg_wr_en,
    input  logic [lsf_pkg::CNT_W-1:0]        i_cfg_wr_data,
    input  logic [lsf_pkg::X_W-1:0]          i_x,
    input  logic [lsf_pkg::X_W-1:0]          i_y,
    output lsf_pkg::t_lsf_sts                o_sts,
    output logic signed [lsf_pkg::Q_W-1:0]   o_slope,
    output logic signed [lsf_pkg::Q_W-1:0]   o_intercept,
    output logic [lsf_pkg::ST_W-1:0]         o_fit_status,
    output logic [lsf_pkg::CNT_W-1:0]        o_point_count
);

    localparam int CNT_W   = lsf_pkg::CNT_W;
    localparam int SX_W    = lsf_pkg::SX_W;
    localparam int SXX_W   = lsf_pkg::SXX_W;
    localparam int MUL_A_W = lsf_pkg::MUL_A_W;
    localparam int MUL_B_W = lsf_pkg::MUL_B_W;
    localparam int PROD_W  = lsf_pkg::PROD_W;
    localparam int ACC_W   = lsf_pkg::ACC_W;
    localparam int DEN_W   = lsf_pkg::DEN_W;
    localparam int Q_W     = lsf_pkg::Q_W;
    localparam int DIV_N_W = lsf_pkg::DIV_N_W;

    // running sums of the set
    logic [CNT_W-1:0] r_count;
    logic [SX_W-1:0]  r_sum_x, r_sum_y;
    logic [SXX_W-1:0] r_sum_xx, r_sum_xy;
    logic             r_ovf;
    logic [CNT_W-1:0] r_min_points;

    // fit datapath
    logic               r_prod_vld, r_prod_hi;
    logic [PROD_W-1:0]  r_prod;
    logic [ACC_W-1:0]   r_acc, r_ta;
    logic [DEN_W-1:0]   r_den;
    logic               r_den_bad;
    logic               r_neg;
    logic [DIV_N_W-1:0] r_num;
    logic [DEN_W-1:0]   r_rem;
    logic [Q_W-1:0]     r_q;
    logic               r_q_ovf;
    logic [Q_W-1:0]     r_slope, r_icpt;

    logic [Q_W-1:0]          r_o_slope, r_o_icpt;
    lsf_pkg::t_fit_status    r_o_status;
    logic [CNT_W-1:0]        r_o_count;

    logic [MUL_A_W-1:0] mul_a;
    logic [SXX_W-1:0]   mul_b;
    logic [MUL_B_W-1:0] mul_b_half;
    logic [ACC_W:0]     diff;
    logic               diff_neg;
    logic [ACC_W-1:0]   diff_mag;
    logic [DEN_W:0]     rem_sh;
    logic               rem_ge;
    logic [Q_W-1:0]     q_sat;

    function automatic logic [Q_W-1:0] sat_q(input logic neg, input logic ovf,
                                             input logic [Q_W-1:0] q);
        logic [Q_W-1:0] res;
        if (neg) begin
            res = (ovf || q[Q_W-1]) ? {1'b1, {(Q_W-1){1'b0}}} : (~q + 1'b1);
        end else begin
            res = (ovf || q[Q_W-1]) ? {1'b0, {(Q_W-1){1'b1}}} : q;
        end
        return res;
    endfunction

    always_comb begin
        case (i_cmd.mop)
            lsf_pkg::MOP_N_XX: begin
                mul_a = MUL_A_W'(r_count);
                mul_b = r_sum_xx;
            end
            lsf_pkg::MOP_X_X: begin
                mul_a = r_sum_x;
                mul_b = SXX_W'(r_sum_x);
            end
            lsf_pkg::MOP_N_XY: begin
                mul_a = MUL_A_W'(r_count);
                mul_b = r_sum_xy;
            end
            lsf_pkg::MOP_X_Y: begin
                mul_a = r_sum_x;
                mul_b = SXX_W'(r_sum_y);
            end
            lsf_pkg::MOP_Y_XX: begin
                mul_a = r_sum_y;
                mul_b = r_sum_xx;
            end
            lsf_pkg::MOP_X_XY: begin
                mul_a = r_sum_x;
                mul_b = r_sum_xy;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_b_half = i_cmd.mul_hi ? MUL_B_W'(mul_b >> MUL_B_W) : mul_b[MUL_B_W-1:0];

    assign diff     = {1'b0, r_ta} - {1'b0, r_acc};
    assign diff_neg = diff[ACC_W];
    assign diff_mag = diff_neg ? (r_acc - r_ta) : diff[ACC_W-1:0];

    assign rem_sh = {r_rem, r_num[DIV_N_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_den});
    assign q_sat  = sat_q(r_neg, r_q_ovf, r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_sum_x      <= '0;
            r_sum_y      <= '0;
            r_sum_xx     <= '0;
            r_sum_xy     <= '0;
            r_ovf        <= 1'b0;
            r_min_points <= CNT_W'(lsf_pkg::MIN_POINTS_RST);
            r_prod_vld   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_min_points <= i_cfg_wr_data;
            end
            r_prod_vld <= i_cmd.mul_en;
            if (i_cmd.clear) begin
                r_count  <= '0;
                r_sum_x  <= '0;
                r_sum_y  <= '0;
                r_sum_xx <= '0;
                r_sum_xy <= '0;
                r_ovf    <= 1'b0;
            end else if (i_cmd.accum) begin
                // drop points beyond the set limit, but remember it
                if (r_count < CNT_W'(lsf_pkg::MAX_POINTS)) begin
                    r_count  <= r_count + 1'b1;
                    r_sum_x  <= r_sum_x + SX_W'(i_x);
                    r_sum_y  <= r_sum_y + SX_W'(i_y);
                    r_sum_xx <= r_sum_xx + SXX_W'(i_x * i_x);
                    r_sum_xy <= r_sum_xy + SXX_W'(i_x * i_y);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod    <= mul_a * mul_b_half;
            r_prod_hi <= i_cmd.mul_hi;
        end
        if (r_prod_vld) begin
            r_acc <= r_prod_hi ? (r_acc + (ACC_W'(r_prod) << MUL_B_W)) : ACC_W'(r_prod);
        end
        if (i_cmd.store_ta) begin
            r_ta <= r_acc;
        end
        if (i_cmd.store_den) begin
            r_den     <= diff[DEN_W-1:0];
            r_den_bad <= diff_neg || (diff == '0);
        end
        if (i_cmd.store_num) begin
            r_neg   <= diff_neg;
            r_num   <= DIV_N_W'(diff_mag) << (i_cmd.shift_icpt ? lsf_pkg::ICPT_SHIFT
                                                                : lsf_pkg::SLOPE_SHIFT);
            r_rem   <= '0;
            r_q     <= '0;
            r_q_ovf <= 1'b0;
        end else if (i_cmd.div_step) begin
            // one restoring step; quotient bits above Q_W only set the sticky flag
            r_rem   <= rem_ge ? DEN_W'(rem_sh - {1'b0, r_den}) : DEN_W'(rem_sh);
            r_num   <= r_num << 1;
            r_q     <= {r_q[Q_W-2:0], rem_ge};
            r_q_ovf <= r_q_ovf | r_q[Q_W-1];
        end
        if (i_cmd.save_slope) begin
            r_slope <= q_sat;
        end
        if (i_cmd.save_icpt) begin
            r_icpt <= q_sat;
        end
        if (i_cmd.publish) begin
            r_o_slope  <= (i_cmd.status == lsf_pkg::FIT_OK) ? r_slope : '0;
            r_o_icpt   <= (i_cmd.status == lsf_pkg::FIT_OK) ? r_icpt : '0;
            r_o_status <= i_cmd.status;
            r_o_count  <= r_count;
        end
    end

    assign o_sts.overflowed = r_ovf;
    assign o_sts.too_few    = (r_count < r_min_points) ||
                              (r_count < CNT_W'(lsf_pkg::MIN_FIT_POINTS));
    assign o_sts.den_bad    = r_den_bad;

    assign o_slope       = r_o_slope;
    assign o_intercept   = r_o_icpt;
    assign o_fit_status  = r_o_status;
    assign o_point_count = r_o_count;

endmodule

FILE: design/least_squares_line_fit.sv
// Least-squares line fit over a set of calibration points.
// i_point carries one point per transfer (payload_mass Q8.8, energy_per_km Q12.4,
// last). Points are summed at one per cycle; a point past the 256-point limit is
// dropped and marks the set as overflowed. The point with last set closes the set.
// o_result carries one item per set: slope and intercept in signed Q16.16,
// fit_status and point_count. i_cfg_wr_en / i_cfg_wr_data write min_points
// (reset value 5); write it only while no set is in progress.
// After the last point, a set that overflowed or has too few points goes
// straight to the output register; otherwise n*Sxx - Sx*Sx is formed, a zero
// spread ends the fit, and the slope and then the intercept are divided out.
// The fit takes six 24x40 products on one 24x20 multiplier and two 76-step
// restoring divisions, one quotient bit per cycle. i_point.ready is low from
// the last point until the result is in the output register.
// The output register holds a result until taken; a new set may be summed
// meanwhile, but its result waits until the previous one is transferred.
// Synchronous reset clears the sums, drops any pending result and sets
// min_points to 5.
module least_squares_line_fit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lsf_point_if.sink                   i_point,
    lsf_result_if.source                o_result,
    input  logic                        i_cfg_wr_en,
    input  logic [lsf_pkg::CNT_W-1:0]   i_cfg_wr_data
);

    lsf_pkg::t_lsf_cmd cmd;
    lsf_pkg::t_lsf_sts sts;

    lsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_point.valid),
        .i_in_last   (i_point.last),
        .i_out_ready (o_result.ready),
        .i_sts       (sts),
        .o_in_ready  (i_point.ready),
        .o_out_valid (o_result.valid),
        .o_cmd       (cmd)
    );

    lsf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_x           (i_point.payload_mass),
        .i_y           (i_point.energy_per_km),
        .o_sts         (sts),
        .o_slope       (o_result.slope),
        .o_intercept   (o_result.intercept),
        .o_fit_status  (o_result.fit_status),
        .o_point_count (o_result.point_count)
    );

endmodule

FILE: design/lsf_checker.sv
module lsf_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_pt_valid,
    input logic                              i_pt_ready,
    input logic                              i_pt_last,
    input logic                              i_res_valid,
    input logic                              i_res_ready,
    input logic signed [lsf_pkg::Q_W-1:0]    i_res_slope,
    input logic signed [lsf_pkg::Q_W-1:0]    i_res_intercept,
    input logic [lsf_pkg::ST_W-1:0]          i_res_fit_status,
    input logic [lsf_pkg::CNT_W-1:0]         i_res_point_count
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result offered after reset");

    // the transfer closing a set stops intake while the fit runs
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pt_valid && i_pt_ready && i_pt_last |=> !i_pt_ready)
        else $error("point taken right after the last point");

    a_unfit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_fit_status != lsf_pkg::FIT_OK) |->
            (i_res_slope == '0) && (i_res_intercept == '0))
        else $error("nonzero coefficients without a fit");

    a_fit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_fit_status == lsf_pkg::FIT_OK) |->
            (i_res_point_count >= lsf_pkg::CNT_W'(lsf_pkg::MIN_FIT_POINTS)) &&
            (i_res_point_count <= lsf_pkg::CNT_W'(lsf_pkg::MAX_POINTS)))
        else $error("fit reported with a bad point count");

endmodule

bind least_squares_line_fit lsf_checker u_lsf_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_pt_valid        (i_point.valid),
    .i_pt_ready        (i_point.ready),
    .i_pt_last         (i_point.last),
    .i_res_valid       (o_result.valid),
    .i_res_ready       (o_result.ready),
    .i_res_slope       (o_result.slope),
    .i_res_intercept   (o_result.intercept),
    .i_res_fit_status  (o_result.fit_status),
    .i_res_point_count (o_result.point_count)
);

FILE: tb/lsf_fit_checker.sv
module lsf_fit_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    lsf_point_if                      i_point,
    lsf_result_if                     i_result,
    input  logic                      i_cfg_wr_en,
    input  logic [lsf_pkg::CNT_W-1:0] i_cfg_wr_data,
    output int                        o_errors,
    output int                        o_fits_pending
);

    typedef struct packed {
        logic signed [lsf_pkg::Q_W-1:0] slope;
        logic signed [lsf_pkg::Q_W-1:0] intercept;
        lsf_pkg::t_fit_status           status;
        logic [lsf_pkg::CNT_W-1:0]      count;
    } t_fit_expect;

    t_fit_expect               fit_expect_q[$];
    t_fit_expect               want;
    logic [lsf_pkg::CNT_W-1:0] min_pts;
    logic [lsf_pkg::CNT_W-1:0] n_pts;
    logic [lsf_pkg::SX_W-1:0]  sum_x;
    logic [lsf_pkg::SX_W-1:0]  sum_y;
    logic [lsf_pkg::SXX_W-1:0] sum_xx;
    logic [lsf_pkg::SXX_W-1:0] sum_xy;
    logic                      set_ovf;
    int                        mismatch_cnt = 0;

    assign o_errors = mismatch_cnt;

    task automatic report_mismatch(input string what, input logic [lsf_pkg::Q_W-1:0] got,
                                   input logic [lsf_pkg::Q_W-1:0] exp_val);
        mismatch_cnt++;
        $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, exp_val);
    endtask

    task automatic clear_sums();
        n_pts   = '0;
        sum_x   = '0;
        sum_y   = '0;
        sum_xx  = '0;
        sum_xy  = '0;
        set_ovf = 1'b0;
    endtask

    // (plus - minus) << sh / den, truncated toward zero, saturated to Q16.16
    function automatic logic [lsf_pkg::Q_W-1:0] scaled_ratio(input logic [127:0] plus,
                                                             input logic [127:0] minus,
                                                             input logic [127:0] den,
                                                             input int unsigned sh);
        logic [127:0] mag;
        logic [127:0] quo;
        logic         neg;
        neg = plus < minus;
        mag = neg ? minus - plus : plus - minus;
        quo = (mag << sh) / den;
        if (neg)
            return (quo >= 128'h8000_0000) ? 32'h8000_0000 : 32'h0 - quo[31:0];
        return (quo > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
    endfunction

    function automatic t_fit_expect fit_line();
        logic [127:0] n_w;
        logic [127:0] sx_w;
        logic [127:0] sy_w;
        logic [127:0] sxx_w;
        logic [127:0] sxy_w;
        logic [127:0] nxx;
        logic [127:0] xx;
        t_fit_expect  r;
        n_w         = 128'(n_pts);
        sx_w        = 128'(sum_x);
        sy_w        = 128'(sum_y);
        sxx_w       = 128'(sum_xx);
        sxy_w       = 128'(sum_xy);
        r.slope     = '0;
        r.intercept = '0;
        r.count     = n_pts;
        if (set_ovf) begin
            r.status = lsf_pkg::FIT_OVF;
        end else if (n_pts < min_pts || n_pts < lsf_pkg::MIN_FIT_POINTS) begin
            r.status = lsf_pkg::FIT_FEW;
        end else begin
            nxx = n_w * sxx_w;
            xx  = sx_w * sx_w;
            if (nxx <= xx) begin
                r.status = lsf_pkg::FIT_FLAT;
            end else begin
                r.status    = lsf_pkg::FIT_OK;
                r.slope     = scaled_ratio(n_w * sxy_w, sx_w * sy_w, nxx - xx,
                                           lsf_pkg::SLOPE_SHIFT);
                r.intercept = scaled_ratio(sy_w * sxx_w, sx_w * sxy_w, nxx - xx,
                                           lsf_pkg::ICPT_SHIFT);
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            min_pts = lsf_pkg::CNT_W'(lsf_pkg::MIN_POINTS_RST);
            clear_sums();
            fit_expect_q.delete();
        end else begin
            if (i_cfg_wr_en)
                min_pts = i_cfg_wr_data;

            if (i_result.valid && i_result.ready) begin
                if (fit_expect_q.size() == 0) begin
                    report_mismatch("result with no closed set",
                                    lsf_pkg::Q_W'(i_result.fit_status), '0);
                end else begin
                    want = fit_expect_q.pop_front();
                    if (i_result.slope !== want.slope)
                        report_mismatch("slope", i_result.slope, want.slope);
                    if (i_result.intercept !== want.intercept)
                        report_mismatch("intercept", i_result.intercept, want.intercept);
                    if (i_result.fit_status !== want.status)
                        report_mismatch("fit_status", lsf_pkg::Q_W'(i_result.fit_status),
                                        lsf_pkg::Q_W'(want.status));
                    if (i_result.point_count !== want.count)
                        report_mismatch("point_count", lsf_pkg::Q_W'(i_result.point_count),
                                        lsf_pkg::Q_W'(want.count));
                end
            end

            if (i_point.valid && i_point.ready) begin
                // drop points past the limit but remember the set overflowed
                if (n_pts < lsf_pkg::MAX_POINTS) begin
                    n_pts  = n_pts + 1'b1;
                    sum_x  = sum_x + lsf_pkg::SX_W'(i_point.payload_mass);
                    sum_y  = sum_y + lsf_pkg::SX_W'(i_point.energy_per_km);
                    sum_xx = sum_xx + lsf_pkg::SXX_W'(i_point.payload_mass) *
                                      lsf_pkg::SXX_W'(i_point.payload_mass);
                    sum_xy = sum_xy + lsf_pkg::SXX_W'(i_point.payload_mass) *
                                      lsf_pkg::SXX_W'(i_point.energy_per_km);
                end else begin
                    set_ovf = 1'b1;
                end
                if (i_point.last) begin
                    fit_expect_q.push_back(fit_line());
                    clear_sums();
                end
            end
        end
        o_fits_pending <= fit_expect_q.size();
    end

endmodule

FILE: tb/testbench.sv
module testbench;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [lsf_pkg::CNT_W-1:0] cfg_wr_data;
    int                        errors;
    int                        fits_pending;
    int                        src_idle_pct = 22;
    int                        snk_idle_pct = 74;

    lsf_point_if  point_ch();
    lsf_result_if result_ch();

    least_squares_line_fit u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_point       (point_ch),
        .o_result      (result_ch),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    lsf_fit_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_point        (point_ch),
        .i_result       (result_ch),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .o_errors       (errors),
        .o_fits_pending (fits_pending)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        result_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    initial begin
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // hold valid low for random idle cycles, then present one point until transfer
    task automatic put_point(input logic [lsf_pkg::X_W-1:0] x,
                             input logic [lsf_pkg::X_W-1:0] y,
                             input logic lst);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            point_ch.valid <= 1'b0;
            @(posedge clk);
        end
        point_ch.valid         <= 1'b1;
        point_ch.payload_mass  <= x;
        point_ch.energy_per_km <= y;
        point_ch.last          <= lst;
        @(posedge clk);
        while (!point_ch.ready)
            @(posedge clk);
    endtask

    // let every pending fit come out, then give the block time to settle
    task automatic wait_drained();
        point_ch.valid <= 1'b0;
        @(posedge clk);
        while (fits_pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_min_points(input logic [lsf_pkg::CNT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_set(input int len);
        int                      xm;
        int                      ym;
        int                      k;
        int                      sgn;
        int                      noise;
        int                      yv;
        logic [lsf_pkg::X_W-1:0] x_base;
        logic [lsf_pkg::X_W-1:0] y_base;
        logic [lsf_pkg::X_W-1:0] x;
        logic [lsf_pkg::X_W-1:0] y;
        xm     = $urandom_range(0, 9);
        ym     = $urandom_range(0, 3);
        k      = $urandom_range(0, 8);
        sgn    = $urandom_range(0, 1) ? 1 : -1;
        x_base = lsf_pkg::X_W'($urandom);
        y_base = lsf_pkg::X_W'($urandom);
        for (int i = 0; i < len; i++) begin
            if (xm <= 4)
                x = lsf_pkg::X_W'($urandom);
            else if (xm <= 7)
                x = x_base + lsf_pkg::X_W'($urandom_range(0, 3));
            else if (xm == 8)
                x = x_base;
            else
                x = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;

            if (ym <= 1) begin
                y = lsf_pkg::X_W'($urandom);
            end else if (ym == 2) begin
                // roughly linear data with a little noise, clamped to the field
                noise = $urandom_range(0, 6);
                yv    = int'(y_base) + sgn * int'(x >> k) + noise - 3;
                if (yv < 0)
                    yv = 0;
                if (yv > 65535)
                    yv = 65535;
                y = yv[lsf_pkg::X_W-1:0];
            end else begin
                y = y_base;
            end
            put_point(x, y, i == len - 1);
        end
    endtask

    initial begin
        int sent;
        int len;
        int r;
        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_wr_data            = '0;
        point_ch.valid         = 1'b0;
        point_ch.payload_mass  = '0;
        point_ch.energy_per_km = '0;
        point_ch.last          = 1'b0;
        result_ch.ready        = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset value of min_points: single point, short set, flat set, full fit
        put_point(16'h1234, 16'h0100, 1'b1);
        put_point(16'h0000, 16'hFFFF, 1'b0);
        put_point(16'hFFFF, 16'h0000, 1'b0);
        put_point(16'h0064, 16'h0005, 1'b1);
        put_point(16'hFFFF, 16'h0000, 1'b0);
        put_point(16'hFFFF, 16'hFFFF, 1'b0);
        put_point(16'hFFFF, 16'h0001, 1'b0);
        put_point(16'hFFFF, 16'h0002, 1'b0);
        put_point(16'hFFFF, 16'h0003, 1'b1);
        put_point(16'h0000, 16'hFFFF, 1'b0);
        put_point(16'hFFFF, 16'h0000, 1'b0);
        put_point(16'h8000, 16'hAAAA, 1'b0);
        put_point(16'h00FF, 16'h0F0F, 1'b0);
        put_point(16'h5555, 16'h8001, 1'b1);
        wait_drained();

        // no minimum: one point is still too few; tiny spread saturates both ways
        write_min_points(9'd0);
        put_point(16'hABCD, 16'h4321, 1'b1);
        put_point(16'hFFFE, 16'h0000, 1'b0);
        put_point(16'hFFFF, 16'hFFFF, 1'b1);
        put_point(16'hFFFE, 16'hFFFF, 1'b0);
        put_point(16'hFFFF, 16'h0000, 1'b1);

        for (int seg = 0; seg < 20; seg++) begin
            wait_drained();
            if (seg == 7) begin
                src_idle_pct <= 74;
                snk_idle_pct <= 22;
            end else if (seg == 14) begin
                src_idle_pct <= 0;
                snk_idle_pct <= 0;
            end
            case (seg % 8)
                0:       write_min_points(9'd2);
                1:       write_min_points(9'd5);
                2:       write_min_points(9'd0);
                3:       write_min_points(9'd256);
                4:       write_min_points(9'd3);
                5:       write_min_points(9'd511);
                6:       write_min_points(9'd1);
                default: write_min_points(lsf_pkg::CNT_W'($urandom_range(0, 511)));
            endcase
            sent = 0;
            // a full set and an overflowing set at fixed points of the run
            if (seg % 7 == 3) begin
                send_set(lsf_pkg::MAX_POINTS);
                sent = lsf_pkg::MAX_POINTS;
            end else if (seg % 7 == 5) begin
                len = lsf_pkg::MAX_POINTS + 1 + int'($urandom_range(0, 12));
                send_set(len);
                sent = len;
            end
            while (sent < 30) begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    len = 1;
                else if (r < 78)
                    len = $urandom_range(2, 8);
                else if (r < 98)
                    len = $urandom_range(9, 32);
                else
                    len = $urandom_range(240, 300);
                send_set(len);
                sent += len;
            end
        end
        wait_drained();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
